>>> rtl/core/slp_pkg.sv
// slp_pkg: types, codes and helpers for the s-record line parser
// no dependencies; imported by slp_step, srecord_line_parser_core, the checker and tb_top
`timescale 1ns / 1ps

package slp_pkg;

  // characters of the record syntax
  localparam logic [7:0] CH_S     = 8'h53;  // 'S'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_A     = 8'h41;  // 'A'
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd10;

  // record types
  localparam logic [2:0] REC_HEADER  = 3'd0;
  localparam logic [2:0] REC_DATA32  = 3'd3;
  localparam logic [2:0] REC_START32 = 3'd7;

  // s3 layout
  localparam logic [7:0] ADDR_BYTES = 8'd4;
  localparam logic [7:0] HDR_LEN    = 8'd5;  // address bytes plus checksum
  localparam logic [7:0] DLEN_ONE   = 8'd1;
  localparam logic [7:0] DLEN_EIGHT = 8'd8;
  localparam logic [7:0] DLEN_MAX   = 8'd16;
  localparam logic [7:0] SUM_GOOD   = 8'hFF;

  // result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // line status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_PARSE    = 3'd1;
  localparam logic [2:0] ST_CHECKSUM = 3'd2;
  localparam logic [2:0] ST_LENGTH   = 3'd3;
  localparam logic [2:0] ST_SHORT    = 3'd4;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_TYPE  = 3'd1,
    PH_COUNT = 3'd2,
    PH_BODY  = 3'd3,
    PH_DONE  = 3'd4,
    PH_ERROR = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       terminator;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [3:0]  byte_index;
    logic [2:0]  status;
    logic [2:0]  record_type;
    logic [31:0] address;
    logic [7:0]  data_length;
    logic [31:0] line_number;
  } out_item_t;

  // parser state carried from item to item
  typedef struct packed {
    phase_t      phase;
    logic [3:0]  high_nybble;
    logic        have_high;
    logic [7:0]  byte_count;
    logic [7:0]  body_index;
    logic [7:0]  running_sum;
    logic [2:0]  kept_type;
    logic [31:0] kept_address;
    logic [2:0]  first_error;
    logic [31:0] line_counter;
  } parse_state_t;

  // digits map to their value, anything else to c - 'A' + 10, no check
  function automatic logic [7:0] hex_val(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return c - CH_ZERO;
    end
    return c - CH_A + HEX_ALPHA_OFS;
  endfunction

endpackage

>>> rtl/core/slp_step.sv
// slp_step: next-state and result logic for one character or terminator
// depends on slp_pkg
`timescale 1ns / 1ps

module slp_step import slp_pkg::*; (
  input  parse_state_t cur,
  input  in_item_t     item,
  output parse_state_t nxt,
  output logic         res_valid,
  output out_item_t    res
);

  logic [7:0] nyb;
  logic [7:0] asm_byte;
  logic [7:0] type_digit;
  logic [7:0] dlen;
  logic [7:0] len_now;
  logic [7:0] idx_after;
  logic [2:0] st;
  logic       have_count;
  logic [31:0] lnum;

  assign nyb        = hex_val(item.ch);
  assign asm_byte   = {cur.high_nybble, 4'b0000} + nyb;
  assign type_digit = item.ch - CH_ZERO;
  assign dlen       = asm_byte - HDR_LEN;
  assign idx_after  = cur.body_index + 8'd1;
  assign lnum       = cur.line_counter + 32'd1;

  always_comb begin
    case (cur.kept_type)
      REC_DATA32: len_now = cur.byte_count - HDR_LEN;
      REC_HEADER: len_now = cur.byte_count;
      default:    len_now = 8'd0;
    endcase
  end

  always_comb begin
    case (cur.phase)
      PH_ERROR: st = cur.first_error;
      PH_DONE:  st = (cur.running_sum == SUM_GOOD) ? ST_OK : ST_CHECKSUM;
      default:  st = ST_SHORT;
    endcase
    have_count = (cur.phase == PH_BODY) || (cur.phase == PH_DONE) ||
                 ((cur.phase == PH_ERROR) && (cur.first_error == ST_LENGTH));
  end

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    if (item.terminator) begin
      res_valid       = 1'b1;
      res.kind        = KIND_STATUS;
      res.status      = st;
      res.record_type = (st == ST_PARSE) ? REC_HEADER : cur.kept_type;
      res.address     = ((st == ST_PARSE) || (st == ST_LENGTH) ||
                         (cur.kept_type == REC_HEADER)) ? 32'd0 : cur.kept_address;
      res.data_length = ((st == ST_PARSE) || !have_count) ? 8'd0 : len_now;
      res.line_number = lnum;
      nxt              = '0;
      nxt.phase        = PH_START;
      nxt.line_counter = lnum;
    end else begin
      case (cur.phase)
        PH_START: begin
          if (item.ch == CH_S) begin
            nxt.phase = PH_TYPE;
          end else begin
            nxt.phase       = PH_ERROR;
            nxt.first_error = ST_PARSE;
          end
        end
        PH_TYPE: begin
          if (type_digit == {5'd0, REC_HEADER} || type_digit == {5'd0, REC_DATA32} ||
              type_digit == {5'd0, REC_START32}) begin
            nxt.kept_type = type_digit[2:0];
            nxt.have_high = 1'b0;
            nxt.phase     = PH_COUNT;
          end else begin
            nxt.phase       = PH_ERROR;
            nxt.first_error = ST_PARSE;
          end
        end
        PH_COUNT: begin
          if (!cur.have_high) begin
            nxt.high_nybble = nyb[3:0];
            nxt.have_high   = 1'b1;
          end else begin
            nxt.have_high   = 1'b0;
            nxt.byte_count  = asm_byte;
            nxt.running_sum = asm_byte;
            nxt.body_index  = 8'd0;
            if ((cur.kept_type == REC_DATA32) &&
                !(dlen inside {DLEN_ONE, DLEN_EIGHT, DLEN_MAX})) begin
              nxt.phase       = PH_ERROR;
              nxt.first_error = ST_LENGTH;
            end else begin
              nxt.phase = (asm_byte == 8'd0) ? PH_DONE : PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (!cur.have_high) begin
            nxt.high_nybble = nyb[3:0];
            nxt.have_high   = 1'b1;
          end else begin
            nxt.have_high   = 1'b0;
            nxt.running_sum = cur.running_sum + asm_byte;
            if ((cur.body_index < ADDR_BYTES) && (cur.kept_type != REC_HEADER)) begin
              nxt.kept_address = {cur.kept_address[23:0], asm_byte};
            end
            // data bytes sit between the address and the checksum
            if ((cur.kept_type == REC_DATA32) && (cur.body_index >= ADDR_BYTES) &&
                ({1'b0, cur.body_index} + 9'd1 < {1'b0, cur.byte_count})) begin
              res_valid       = 1'b1;
              res.kind        = KIND_DATA;
              res.data_byte   = asm_byte;
              res.byte_index  = 4'(cur.body_index - ADDR_BYTES);
              res.status      = ST_OK;
              res.record_type = REC_DATA32;
              res.address     = cur.kept_address;
              res.data_length = len_now;
              res.line_number = lnum;
            end
            nxt.body_index = idx_after;
            if (idx_after == cur.byte_count) begin
              nxt.phase = PH_DONE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/core/srecord_line_parser_core.sv
// srecord_line_parser_core: top level of the s-record line parser
// depends on slp_pkg and slp_step
`timescale 1ns / 1ps

// Streaming parser for S0/S3/S7 record lines. Feed one character per item
// on the in_ channel and close each line with an item whose terminator bit
// is set (its ch is ignored). Every S3 data byte comes out on the out_
// channel as soon as its second hex character is taken (kind 0), and each
// terminator yields one line status item (kind 1) with status, type,
// address, data length and the running line number. Hex digits are not
// validated. Throughput is one item per clock: the parser state updates in
// the cycle an item is accepted and the result lands in an output register
// backed by a one-entry skid stage, so in_stall rises only when both hold
// results that the consumer has not yet taken. No clearing pass after reset.

module srecord_line_parser_core import slp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  parse_state_t state_r;
  parse_state_t state_nxt;
  logic         res_valid;
  out_item_t    res;

  logic         out_valid_r;
  out_item_t    out_item_r;
  logic         skid_valid_r;
  out_item_t    skid_item_r;

  logic         in_acc;
  logic         out_acc;

  // per-item decode: short logic from parser state to result
  slp_step u_step (
    .cur       (state_r),
    .item      (in_item),
    .nxt       (state_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  // the skid entry being busy is the only reason to refuse an item
  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_acc  = out_valid_r && !out_stall;

  // parser state advances on every accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // output register plus skid stage, order kept: skid always drains first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        // input is stalled here, only the skid can move
        if (out_acc) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (in_acc && res_valid) begin
        if (out_valid_r && out_stall) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_acc) begin
        out_item_r <= skid_item_r;
      end
    end else if (in_acc && res_valid) begin
      if (out_valid_r && out_stall) begin
        skid_item_r <= res;
      end else begin
        out_item_r <= res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> rtl/core/slp_checker.sv
// slp_checker: port-level assertions for srecord_line_parser_core
// depends on slp_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps

module slp_checker import slp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  // a stalled input item is held by the sender
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input item changed or dropped");

  // input is only refused while a result was waiting on the consumer
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(out_valid && out_stall))
    else $error("input stalled without output backpressure");

  // reset empties both result stages
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result stages not empty after reset");

  // data items carry ok status and type 3 only
  a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.kind == KIND_DATA) |->
      (out_item.status == ST_OK) && (out_item.record_type == REC_DATA32))
    else $error("data item with bad status or type");

endmodule

bind srecord_line_parser_core slp_checker u_slp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

>>> verif/tb_top.sv
// tb_top: self-checking testbench for srecord_line_parser_core
// depends on slp_pkg and the parser rtl; drives lines one character per item
`timescale 1ns / 1ps

module tb_top;
  import slp_pkg::*;

  // receiver hold-off length for the back-pressure test
  localparam int HOLD_CYCLES = 300;
  // cap on printed mismatch lines, counting goes on past it
  localparam int PRINT_CAP = 200;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  srecord_line_parser_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // free-running 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #(2_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------
  // shadow parser state, updated once per accepted input item
  // ---------------------------------------------------------------------
  phase_t      ps_phase = PH_START;
  logic [7:0]  ps_hi = '0;
  logic        ps_have_hi = 1'b0;
  logic [7:0]  ps_count = '0;
  logic [7:0]  ps_index = '0;
  logic [7:0]  ps_sum = '0;
  logic [2:0]  ps_type = '0;
  logic [31:0] ps_addr = '0;
  logic [2:0]  ps_err = ST_OK;
  logic [31:0] ps_lines = '0;

  // results the parser still owes us, oldest first
  out_item_t   expected_q[$];
  out_item_t   want_r;

  int          mismatches = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_requests = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  // characters of the line under construction
  logic [7:0]  line_buf[$];
  int          mangle_pct = 0;

  // hex digit without any validity check, wraps mod 256
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return c - CH_ZERO;
    end
    return c + HEX_ALPHA_OFS - CH_A;
  endfunction

  // data length field as the parser reports it for the kept type
  function automatic logic [7:0] line_length();
    if (ps_type == REC_DATA32) begin
      return ps_count - HDR_LEN;
    end
    if (ps_type == REC_HEADER) begin
      return ps_count;
    end
    return '0;
  endfunction

  function automatic logic [7:0] type_char(input logic [2:0] t);
    return CH_ZERO + {5'd0, t};
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return CH_ZERO + {4'd0, n};
    end
    return CH_A + {4'd0, n} - HEX_ALPHA_OFS;
  endfunction

  // everything but the line counter goes back to zero after a terminator
  task automatic clear_line_state();
    ps_phase   = PH_START;
    ps_hi      = '0;
    ps_have_hi = 1'b0;
    ps_count   = '0;
    ps_index   = '0;
    ps_sum     = '0;
    ps_type    = '0;
    ps_addr    = '0;
    ps_err     = ST_OK;
  endtask

  // two characters make one byte, first one is the high nybble
  task automatic take_digit(input logic [7:0] c, output logic got, output logic [7:0] b);
    logic [7:0] n;
    n   = digit_value(c);
    got = 1'b0;
    b   = '0;
    if (!ps_have_hi) begin
      ps_hi      = n;
      ps_have_hi = 1'b1;
    end else begin
      ps_have_hi = 1'b0;
      b          = (ps_hi << 4) + n;
      got        = 1'b1;
    end
  endtask

  // advance the shadow parser by one item and queue what it should emit
  task automatic parse_item(input in_item_t it);
    out_item_t  r;
    logic [2:0] st;
    logic       have_cnt;
    logic       got;
    logic [7:0] b;
    logic [7:0] d;
    logic [7:0] pos;
    r = '0;
    if (it.terminator) begin
      // line status: first error wins, a finished record is checked by sum
      if (ps_phase == PH_ERROR) begin
        st = ps_err;
      end else if (ps_phase == PH_DONE) begin
        st = (ps_sum == SUM_GOOD) ? ST_OK : ST_CHECKSUM;
      end else begin
        st = ST_SHORT;
      end
      have_cnt = (ps_phase == PH_BODY) || (ps_phase == PH_DONE) ||
                 (ps_phase == PH_ERROR && ps_err == ST_LENGTH);
      ps_lines      = ps_lines + 32'd1;
      r.kind        = KIND_STATUS;
      r.status      = st;
      r.record_type = (st == ST_PARSE) ? REC_HEADER : ps_type;
      r.address     = (st == ST_PARSE || st == ST_LENGTH || ps_type == REC_HEADER) ?
                      32'd0 : ps_addr;
      r.data_length = (st == ST_PARSE || !have_cnt) ? 8'd0 : line_length();
      r.line_number = ps_lines;
      expected_q.push_back(r);
      clear_line_state();
    end else begin
      case (ps_phase)
        PH_START: begin
          if (it.ch == CH_S) begin
            ps_phase = PH_TYPE;
          end else begin
            ps_err   = ST_PARSE;
            ps_phase = PH_ERROR;
          end
        end
        PH_TYPE: begin
          d = it.ch - CH_ZERO;
          if (d == {5'd0, REC_HEADER} || d == {5'd0, REC_DATA32} ||
              d == {5'd0, REC_START32}) begin
            ps_type    = d[2:0];
            ps_have_hi = 1'b0;
            ps_phase   = PH_COUNT;
          end else begin
            ps_err   = ST_PARSE;
            ps_phase = PH_ERROR;
          end
        end
        PH_COUNT: begin
          take_digit(it.ch, got, b);
          if (got) begin
            ps_count = b;
            ps_sum   = b;
            ps_index = '0;
            d        = b - HDR_LEN;
            // s3 length is judged as soon as the count is known
            if (ps_type == REC_DATA32 && d != DLEN_ONE && d != DLEN_EIGHT &&
                d != DLEN_MAX) begin
              ps_err   = ST_LENGTH;
              ps_phase = PH_ERROR;
            end else if (b == 8'd0) begin
              ps_phase = PH_DONE;
            end else begin
              ps_phase = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          take_digit(it.ch, got, b);
          if (got) begin
            ps_sum = ps_sum + b;
            if (ps_index < ADDR_BYTES && ps_type != REC_HEADER) begin
              ps_addr = {ps_addr[23:0], b};
            end
            // s3 data bytes sit between the address and the checksum
            if (ps_type == REC_DATA32 && ps_index >= ADDR_BYTES &&
                ({1'b0, ps_index} + 9'd1) < {1'b0, ps_count}) begin
              pos           = ps_index - ADDR_BYTES;
              r.kind        = KIND_DATA;
              r.data_byte   = b;
              r.byte_index  = pos[3:0];
              r.status      = ST_OK;
              r.record_type = REC_DATA32;
              r.address     = ps_addr;
              r.data_length = line_length();
              r.line_number = ps_lines + 32'd1;
              expected_q.push_back(r);
            end
            ps_index = ps_index + 8'd1;
            if (ps_index == ps_count) begin
              ps_phase = PH_DONE;
            end
          end
        end
        default: begin
          // done or error: characters are dropped until the terminator
        end
      endcase
    end
  endtask

  // every accepted input item feeds the shadow parser
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      parse_item(in_item);
    end
  end

  // ---------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("%0t mismatch %s: got %0h want %0h (line %0d)", $realtime, what, got,
               want, want_r.line_number);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      flag_mismatch(name, got, want);
    end
  endtask

  // each result taken from the block is matched against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        flag_mismatch("unexpected result kind", {31'd0, out_item.kind}, 32'd0);
      end else begin
        want_r = expected_q.pop_front();
        check_field("kind", {31'd0, out_item.kind}, {31'd0, want_r.kind});
        check_field("data_byte", {24'd0, out_item.data_byte}, {24'd0, want_r.data_byte});
        check_field("byte_index", {28'd0, out_item.byte_index},
                    {28'd0, want_r.byte_index});
        check_field("status", {29'd0, out_item.status}, {29'd0, want_r.status});
        check_field("record_type", {29'd0, out_item.record_type},
                    {29'd0, want_r.record_type});
        check_field("address", out_item.address, want_r.address);
        check_field("data_length", {24'd0, out_item.data_length},
                    {24'd0, want_r.data_length});
        check_field("line_number", out_item.line_number, want_r.line_number);
      end
    end
  end

  // ---------------------------------------------------------------------
  // receiver: random stalls, or a long hold-off when the test asks for one
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------
  // offer one item, with a random idle gap ahead of it, and wait until taken
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  // push the buffered characters, then the terminator with a random ch
  task automatic send_line();
    in_item_t it;
    foreach (line_buf[i]) begin
      it.ch         = line_buf[i];
      it.terminator = 1'b0;
      send_item(it);
    end
    it.ch         = 8'($urandom_range(255));
    it.terminator = 1'b1;
    send_item(it);
  endtask

  // two hex characters per byte; mangling swaps in arbitrary characters
  task automatic push_hex(input logic [7:0] b);
    if ($urandom_range(99) < mangle_pct) begin
      line_buf.push_back(8'($urandom_range(255)));
      line_buf.push_back(8'($urandom_range(255)));
    end else begin
      line_buf.push_back(nibble_char(b[7:4]));
      line_buf.push_back(nibble_char(b[3:0]));
    end
  endtask

  // 'S', type, count and keep body bytes; the first four body bytes come
  // from addr, the byte at position count-1 is the checksum when good_sum
  task automatic build_record(input logic [2:0] rtype, input logic [7:0] cnt,
                              input int keep, input logic [31:0] addr,
                              input bit good_sum);
    logic [7:0] sum;
    logic [7:0] b;
    int         i;
    line_buf.delete();
    line_buf.push_back(CH_S);
    line_buf.push_back(type_char(rtype));
    push_hex(cnt);
    sum = cnt;
    for (i = 0; i < keep; i++) begin
      if (i < 4) begin
        b = addr[31 - 8 * i -: 8];
      end else begin
        b = 8'($urandom_range(255));
      end
      if (good_sum && i == int'(cnt) - 1) begin
        b = SUM_GOOD - sum;
      end
      sum = sum + b;
      push_hex(b);
    end
  endtask

  // ---------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------
  // empty line, wrong first character, and a lone 'S'
  task automatic test_bad_start();
    line_buf.delete();
    send_line();
    line_buf.delete();
    line_buf.push_back(8'hD3);  // 'S' with the top bit set
    line_buf.push_back(CH_S);
    send_line();
    line_buf.delete();
    line_buf.push_back(CH_S);
    send_line();
  endtask

  // type digits outside 0, 3, 7
  task automatic test_bad_type();
    line_buf.delete();
    line_buf.push_back(CH_S);
    line_buf.push_back(type_char(3'd5));
    line_buf.push_back(CH_ZERO);
    send_line();
    line_buf.delete();
    line_buf.push_back(CH_S);
    line_buf.push_back(CH_A);
    send_line();
  endtask

  // s0 with a good sum, an empty s0 and a bad sum
  task automatic test_header_records();
    build_record(REC_HEADER, 8'd3, 3, 32'h4844_5200, 1'b1);
    send_line();
    build_record(REC_HEADER, 8'd0, 0, 32'd0, 1'b1);
    send_line();
    build_record(REC_HEADER, 8'd2, 2, 32'hFFFF_0000, 1'b0);
    send_line();
  endtask

  // all legal s3 lengths, address extremes and a bad checksum
  task automatic test_data_records();
    build_record(REC_DATA32, HDR_LEN + DLEN_ONE, 6, 32'h0000_0000, 1'b1);
    send_line();
    build_record(REC_DATA32, HDR_LEN + DLEN_EIGHT, 13, 32'h1234_5678, 1'b1);
    send_line();
    build_record(REC_DATA32, HDR_LEN + DLEN_MAX, 21, 32'hFFFF_FFFF, 1'b1);
    send_line();
    build_record(REC_DATA32, HDR_LEN + DLEN_ONE, 6, 32'h8000_0001, 1'b0);
    send_line();
  endtask

  // s3 counts that give a length outside 1, 8, 16
  task automatic test_bad_length();
    build_record(REC_DATA32, 8'd7, 7, 32'hAAAA_5555, 1'b1);
    send_line();
    build_record(REC_DATA32, 8'd0, 0, 32'd0, 1'b1);
    send_line();
    build_record(REC_DATA32, 8'hFF, 2, 32'd0, 1'b1);
    send_line();
  endtask

  // s7 full, with a short count, and with no body at all
  task automatic test_start_records();
    build_record(REC_START32, 8'd5, 5, 32'hDEAD_BEEF, 1'b1);
    send_line();
    build_record(REC_START32, 8'd2, 2, 32'hC0DE_0000, 1'b1);
    send_line();
    build_record(REC_START32, 8'd0, 0, 32'd0, 1'b1);
    send_line();
  endtask

  // terminator in the count, mid body, and one nybble before the end
  task automatic test_truncated_lines();
    line_buf.delete();
    line_buf.push_back(CH_S);
    line_buf.push_back(type_char(REC_DATA32));
    line_buf.push_back(CH_ZERO);
    send_line();
    build_record(REC_DATA32, HDR_LEN + DLEN_EIGHT, 7, 32'h0102_0304, 1'b1);
    send_line();
    build_record(REC_HEADER, 8'd3, 3, 32'h0000_0000, 1'b1);
    void'(line_buf.pop_back());
    send_line();
  endtask

  // characters after a complete record are dropped
  task automatic test_trailing_chars();
    build_record(REC_DATA32, HDR_LEN + DLEN_ONE, 6, 32'h0000_1000, 1'b1);
    line_buf.push_back(nibble_char(4'hF));
    line_buf.push_back(8'h00);
    line_buf.push_back(CH_S);
    send_line();
  endtask

  // non-hex characters decode through the unchecked mapping
  task automatic test_raw_digits();
    line_buf.delete();
    line_buf.push_back(CH_S);
    line_buf.push_back(type_char(REC_HEADER));
    line_buf.push_back(CH_ZERO);
    line_buf.push_back(CH_ZERO + 8'd2);
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h67);  // lower-case g
    line_buf.push_back(8'h5A);  // Z
    send_line();
    line_buf.delete();
    line_buf.push_back(CH_S);
    line_buf.push_back(type_char(REC_DATA32));
    line_buf.push_back(8'h61);  // lower-case a in the count
    line_buf.push_back(8'h47);  // G
    line_buf.push_back(CH_ZERO);
    send_line();
  endtask

  // receiver holds off while the sender streams dense s3 lines, so both
  // output slots fill and in_stall has to rise
  task automatic test_back_pressure();
    int n;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests <= hold_requests + 1;
    for (n = 0; n < 3; n++) begin
      build_record(REC_DATA32, HDR_LEN + DLEN_MAX, 21, 32'($urandom), 1'b1);
      send_line();
    end
  endtask

  // ---------------------------------------------------------------------
  // random lines: mostly well formed, the rest broken or noise
  // ---------------------------------------------------------------------
  task automatic build_random_line();
    int         pick;
    int         keep;
    int         n;
    logic [2:0] rtype;
    logic [7:0] cnt;
    logic [7:0] dlen;
    pick = $urandom_range(99);
    if (pick < 70) begin
      n = $urandom_range(9);
      if (n < 6) begin
        rtype = REC_DATA32;
        n     = $urandom_range(2);
        dlen  = (n == 0) ? DLEN_ONE : (n == 1) ? DLEN_EIGHT : DLEN_MAX;
        cnt   = HDR_LEN + dlen;
      end else if (n < 8) begin
        rtype = REC_HEADER;
        cnt   = 8'($urandom_range(12));
      end else begin
        rtype = REC_START32;
        cnt   = ($urandom_range(3) == 0) ? 8'($urandom_range(6)) : 8'd5;
      end
      keep = cnt;
      if ($urandom_range(99) < 8) begin
        keep = $urandom_range(cnt);
      end
      build_record(rtype, cnt, keep, 32'($urandom), $urandom_range(99) < 85);
      // half a byte before an early terminator
      if (keep < cnt && $urandom_range(1) == 1) begin
        line_buf.push_back(nibble_char(4'($urandom_range(15))));
      end
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(255)));
      end
    end else if (pick < 80) begin
      // arbitrary type character
      line_buf.delete();
      line_buf.push_back(CH_S);
      line_buf.push_back(8'($urandom_range(255)));
      repeat ($urandom_range(4)) push_hex(8'($urandom_range(255)));
    end else if (pick < 90) begin
      // s3 with any count, usually a length error
      cnt = 8'($urandom_range(255));
      build_record(REC_DATA32, cnt, $urandom_range(8), 32'($urandom), 1'b1);
    end else begin
      // pure noise
      line_buf.delete();
      repeat ($urandom_range(6)) line_buf.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic test_random_lines(input int n_items, input int send_pct,
                                   input int recv_pct);
    int target;
    target        = items_sent + n_items;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    mangle_pct    = 3;
    while (items_sent < target) begin
      build_random_line();
      send_line();
    end
    mangle_pct = 0;
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    int guard;
    // synchronous reset held at the start, once
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 15;
    recv_idle_pct = 56;
    test_bad_start();
    test_bad_type();
    test_header_records();
    test_data_records();
    test_bad_length();
    test_start_records();
    test_truncated_lines();
    test_trailing_chars();
    test_raw_digits();
    test_back_pressure();

    test_random_lines(600, 15, 56);
    test_random_lines(600, 56, 15);
    test_random_lines(600, 0, 0);

    // drain: let every owed result come out, then idle before the final check
    in_valid <= 1'b0;
    guard = 0;
    while (expected_q.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (expected_q.size() != 0) begin
      flag_mismatch("results never arrived", expected_q.size(), 32'd0);
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
